// ----- hw/rtl/oggp_pkg.sv -----
package oggp_pkg;

    // Parser position within a page
    typedef enum logic [3:0] {
        ST_CAP_O    = 4'd0,
        ST_CAP_G1   = 4'd1,
        ST_CAP_G2   = 4'd2,
        ST_CAP_S    = 4'd3,
        ST_VERSION  = 4'd4,
        ST_HTYPE    = 4'd5,
        ST_GRANULE  = 4'd6,
        ST_SERIAL   = 4'd7,
        ST_PAGENO   = 4'd8,
        ST_CHECKSUM = 4'd9,
        ST_SEGCOUNT = 4'd10,
        ST_SEGTABLE = 4'd11,
        ST_DATA     = 4'd12
    } t_state;

    // Status codes of a result word
    localparam logic [1:0] STAT_HEADER  = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_PAYLOAD = 2'd2;
    localparam logic [1:0] STAT_ERROR   = 2'd3;

    // Capture pattern and stream version
    localparam logic [7:0] LETTER_O_UC   = 8'h4F;
    localparam logic [7:0] LETTER_G_LC   = 8'h67;
    localparam logic [7:0] LETTER_S_UC   = 8'h53;
    localparam logic [7:0] STREAM_VERSION = 8'h00;

    // Lane index of the final byte of a field
    localparam logic [2:0] LANE_LAST64 = 3'd7;
    localparam logic [1:0] LANE_LAST32 = 2'd3;

    // Parser context carried from one byte to the next
    typedef struct packed {
        t_state        parse_state;
        logic [2:0]    field_byte_index;
        logic [7:0]    page_type_flags;
        logic [63:0]   granule_value;
        logic [31:0]   stream_serial;
        logic [31:0]   page_sequence;
        logic [7:0]    segment_count;
        logic [7:0]    segment_index;
        logic [15:0]   page_length_sum;
        logic [15:0]   payload_position;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{parse_state: ST_CAP_O, default: '0};

    // One result word
    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         data_byte;
        logic [7:0]         header_type;
        logic signed [63:0] granule_position;
        logic signed [31:0] serial_number;
        logic [31:0]        page_number;
        logic [15:0]        payload_length;
        logic               last_of_page;
    } t_result;

endpackage

// ----- hw/rtl/oggp_in_if.sv -----
interface oggp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/oggp_out_if.sv -----
interface oggp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         data_byte;
    logic [7:0]         header_type;
    logic signed [63:0] granule_position;
    logic signed [31:0] serial_number;
    logic [31:0]        page_number;
    logic [15:0]        payload_length;
    logic               last_of_page;

    modport source (
        output valid, output status, output data_byte, output header_type,
        output granule_position, output serial_number, output page_number,
        output payload_length, output last_of_page, input ready
    );
    modport sink (
        input valid, input status, input data_byte, input header_type,
        input granule_position, input serial_number, input page_number,
        input payload_length, input last_of_page, output ready
    );
endinterface

// ----- hw/rtl/oggp_step.sv -----
module oggp_step (
    input  oggp_pkg::t_ctx    i_ctx,
    input  logic [7:0]        i_byte,
    output oggp_pkg::t_ctx    o_ctx,
    output oggp_pkg::t_result o_res
);

    logic [15:0] w_sum_next;
    logic [7:0]  w_seg_next;
    logic [15:0] w_pos_next;
    logic [1:0]  w_status;
    logic [7:0]  w_data;
    logic        w_last;

    // Running totals for the segment table and the payload
    assign w_sum_next = i_ctx.page_length_sum + {8'd0, i_byte};
    assign w_seg_next = i_ctx.segment_index + 8'd1;
    assign w_pos_next = i_ctx.payload_position + 16'd1;

    // Decode one byte against the current parser position
    always_comb begin
        o_ctx    = i_ctx;
        w_status = oggp_pkg::STAT_HEADER;
        w_data   = 8'd0;
        w_last   = 1'b0;
        unique case (i_ctx.parse_state)
            oggp_pkg::ST_CAP_G1: begin
                if (i_byte == oggp_pkg::LETTER_G_LC) o_ctx.parse_state = oggp_pkg::ST_CAP_G2;
                else w_status = oggp_pkg::STAT_ERROR;
            end
            oggp_pkg::ST_CAP_G2: begin
                if (i_byte == oggp_pkg::LETTER_G_LC) o_ctx.parse_state = oggp_pkg::ST_CAP_S;
                else w_status = oggp_pkg::STAT_ERROR;
            end
            oggp_pkg::ST_CAP_S: begin
                if (i_byte == oggp_pkg::LETTER_S_UC) o_ctx.parse_state = oggp_pkg::ST_VERSION;
                else w_status = oggp_pkg::STAT_ERROR;
            end
            oggp_pkg::ST_VERSION: begin
                if (i_byte == oggp_pkg::STREAM_VERSION) o_ctx.parse_state = oggp_pkg::ST_HTYPE;
                else w_status = oggp_pkg::STAT_ERROR;
            end
            oggp_pkg::ST_HTYPE: begin
                o_ctx.page_type_flags  = i_byte;
                o_ctx.field_byte_index = 3'd0;
                o_ctx.parse_state      = oggp_pkg::ST_GRANULE;
            end
            oggp_pkg::ST_GRANULE: begin
                o_ctx.granule_value[{i_ctx.field_byte_index, 3'b000} +: 8] = i_byte;
                if (i_ctx.field_byte_index == oggp_pkg::LANE_LAST64) begin
                    o_ctx.field_byte_index = 3'd0;
                    o_ctx.parse_state      = oggp_pkg::ST_SERIAL;
                end else begin
                    o_ctx.field_byte_index = i_ctx.field_byte_index + 3'd1;
                end
            end
            oggp_pkg::ST_SERIAL: begin
                o_ctx.stream_serial[{i_ctx.field_byte_index[1:0], 3'b000} +: 8] = i_byte;
                if (i_ctx.field_byte_index[1:0] == oggp_pkg::LANE_LAST32) begin
                    o_ctx.field_byte_index = 3'd0;
                    o_ctx.parse_state      = oggp_pkg::ST_PAGENO;
                end else begin
                    o_ctx.field_byte_index = i_ctx.field_byte_index + 3'd1;
                end
            end
            oggp_pkg::ST_PAGENO: begin
                o_ctx.page_sequence[{i_ctx.field_byte_index[1:0], 3'b000} +: 8] = i_byte;
                if (i_ctx.field_byte_index[1:0] == oggp_pkg::LANE_LAST32) begin
                    o_ctx.field_byte_index = 3'd0;
                    o_ctx.parse_state      = oggp_pkg::ST_CHECKSUM;
                end else begin
                    o_ctx.field_byte_index = i_ctx.field_byte_index + 3'd1;
                end
            end
            oggp_pkg::ST_CHECKSUM: begin
                // skip the CRC bytes
                if (i_ctx.field_byte_index[1:0] == oggp_pkg::LANE_LAST32) begin
                    o_ctx.field_byte_index = 3'd0;
                    o_ctx.parse_state      = oggp_pkg::ST_SEGCOUNT;
                end else begin
                    o_ctx.field_byte_index = i_ctx.field_byte_index + 3'd1;
                end
            end
            oggp_pkg::ST_SEGCOUNT: begin
                o_ctx.segment_count   = i_byte;
                o_ctx.segment_index   = 8'd0;
                o_ctx.page_length_sum = 16'd0;
                if (i_byte == 8'd0) begin
                    // empty table: header done, nothing to pass out
                    o_ctx.payload_position = 16'd0;
                    o_ctx.parse_state      = oggp_pkg::ST_CAP_O;
                    w_status               = oggp_pkg::STAT_DONE;
                end else begin
                    o_ctx.parse_state = oggp_pkg::ST_SEGTABLE;
                end
            end
            oggp_pkg::ST_SEGTABLE: begin
                o_ctx.page_length_sum = w_sum_next;
                o_ctx.segment_index   = w_seg_next;
                if (w_seg_next >= i_ctx.segment_count) begin
                    o_ctx.payload_position = 16'd0;
                    o_ctx.parse_state      = (w_sum_next == 16'd0) ? oggp_pkg::ST_CAP_O
                                                                   : oggp_pkg::ST_DATA;
                    w_status               = oggp_pkg::STAT_DONE;
                end
            end
            oggp_pkg::ST_DATA: begin
                w_status               = oggp_pkg::STAT_PAYLOAD;
                w_data                 = i_byte;
                o_ctx.payload_position = w_pos_next;
                if (w_pos_next >= i_ctx.page_length_sum) begin
                    w_last            = 1'b1;
                    o_ctx.parse_state = oggp_pkg::ST_CAP_O;
                end
            end
            default: begin
                // capture start, also taken by unused codes
                if (i_byte == oggp_pkg::LETTER_O_UC) begin
                    o_ctx.parse_state = oggp_pkg::ST_CAP_G1;
                end else begin
                    o_ctx.parse_state = oggp_pkg::ST_CAP_O;
                    w_status          = oggp_pkg::STAT_ERROR;
                end
            end
        endcase
    end

    // Result word reflects the context after this byte
    always_comb begin
        o_res.status           = w_status;
        o_res.data_byte        = w_data;
        o_res.header_type      = o_ctx.page_type_flags;
        o_res.granule_position = o_ctx.granule_value;
        o_res.serial_number    = o_ctx.stream_serial;
        o_res.page_number      = o_ctx.page_sequence;
        o_res.payload_length   = o_ctx.page_length_sum;
        o_res.last_of_page     = w_last;
    end

endmodule

// ----- hw/rtl/ogg_page_header_parser_core.sv -----
// Ogg page header parser.
// i_in carries one stream byte per word (valid/ready). o_out carries one result
// word for every byte taken: a status (header byte, header complete, payload
// byte, format error), the payload byte, the page fields gathered so far and a
// last-of-page flag on the final payload byte of a page.
// Flow: a byte taken is held in the input register, parsed, and its result word
// is written to the result register, which drives o_out.
// Throughput: one byte per cycle while o_out is ready, set by the single parse
// stage that updates the page context between the input and result registers.
// Stalls: when o_out is not ready the result register holds and the input
// register still takes one more byte; i_in.ready then drops until the result
// word is taken.
// Reset (i_rst_n low, synchronous): both registers empty, the parser expects
// the capture letter O and all page fields of the context read as zero.
module ogg_page_header_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oggp_in_if.sink    i_in,
    oggp_out_if.source o_out
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    oggp_pkg::t_result r_out;
    oggp_pkg::t_ctx    r_ctx;
    oggp_pkg::t_ctx    n_ctx;
    oggp_pkg::t_result n_out;
    logic              w_advance;

    // Move a byte from the input register into the result register
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    oggp_step u_step (
        .i_ctx  (r_ctx),
        .i_byte (r_in_byte),
        .o_ctx  (n_ctx),
        .o_res  (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Parser context, advanced once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= oggp_pkg::CTX_RESET;
        end else if (w_advance) begin
            r_ctx <= n_ctx;
        end
    end

    // Result register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.data_byte        = r_out.data_byte;
    assign o_out.header_type      = r_out.header_type;
    assign o_out.granule_position = r_out.granule_position;
    assign o_out.serial_number    = r_out.serial_number;
    assign o_out.page_number      = r_out.page_number;
    assign o_out.payload_length   = r_out.payload_length;
    assign o_out.last_of_page     = r_out.last_of_page;

endmodule
